// File: hdl/pac_pkg.sv
// Shared types, constants and helpers for the pointer acceleration block.
// No dependencies; imported by pac_datapath, pac_ctrl, the top and the testbench.
package pac_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_THR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_THR = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 8'd7;

    // register reset values
    localparam logic [15:0] RST_GROUP_THR = 16'd100;
    localparam logic [15:0] RST_CLEAR_THR = 16'd500;
    localparam logic [15:0] RST_RATE_GAIN = 16'd256;
    localparam logic [31:0] RST_COEF_A    = 32'h0000_0000;
    localparam logic [31:0] RST_COEF_B    = 32'h0000_0000;
    localparam logic [31:0] RST_COEF_C    = 32'h0001_0000;
    localparam logic [31:0] RST_CEILING   = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_FLOOR     = 32'hFFFF_FFFF;

    localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [47:0] SAT_POS  = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SAT_NEG  = 48'h8000_0000_0000;
    localparam logic [79:0] MAG_POS  = 80'h7FFF_FFFF_FFFF;
    localparam logic [79:0] MAG_NEG  = 80'h8000_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STORE,
        S_WALK_RD,
        S_WALK_ACC,
        S_DIV_INIT,
        S_DIV,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_FIN,
        S_SUM,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        M_DT,
        M_T2,
        M_A,
        M_B,
        M_CRV,
        M_GX,
        M_GY,
        M_OX,
        M_OY
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     store;
        logic     walk;
        logic     div_start;
        logic     div_step;
        logic     mul_lo;
        logic     mul_hi;
        logic     mul_fin;
        logic     sum;
        logic     out_load;
        t_mul_sel sel;
    } t_cmd;

    typedef struct packed {
        logic walk_stop;
        logic div_done;
        logic out_free;
    } t_sts;

    // signed saturation of a product magnitude to 48 bits
    function automatic logic [47:0] sat48(input logic neg, input logic [79:0] mag);
        logic [47:0] res;
        if (neg) begin
            if (mag > MAG_NEG) res = SAT_NEG;
            else               res = 48'd0 - mag[47:0];
        end else begin
            if (mag > MAG_POS) res = SAT_POS;
            else               res = mag[47:0];
        end
        return res;
    endfunction

endpackage

// File: hdl/pac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pac_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/pac_datapath.sv
// Datapath: config registers, history RAM, walk accumulators, three-lane
// divider and a shared 32x32 multiplier. Depends on pac_pkg and pac_ram.
module pac_datapath #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pac_pkg::t_cmd                      i_cmd,
    output pac_pkg::t_sts                      o_sts,
    input  logic                               i_cfg_we,
    input  logic [pac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pac_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [15:0]                 i_motion_x,
    input  logic signed [15:0]                 i_motion_y,
    input  logic [31:0]                        i_time_ms,
    input  logic                               i_clear_history,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [47:0]                 o_scaled_x,
    output logic signed [47:0]                 o_scaled_y
);
    import pac_pkg::*;

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = 15 + CNT_W;
    localparam int DTS_W = 17;
    localparam int DIV_W = ((SUM_W > DTS_W) ? SUM_W : DTS_W) + 8;
    localparam int DC_W  = $clog2(DIV_W + 1);

    // config
    logic [15:0] r_gthr, r_cthr, r_rate;
    logic [31:0] r_coef_a, r_coef_b, r_coef_c, r_ceil, r_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gthr   <= RST_GROUP_THR;
            r_cthr   <= RST_CLEAR_THR;
            r_rate   <= RST_RATE_GAIN;
            r_coef_a <= RST_COEF_A;
            r_coef_b <= RST_COEF_B;
            r_coef_c <= RST_COEF_C;
            r_ceil   <= RST_CEILING;
            r_floor  <= RST_FLOOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GROUP_THR: r_gthr   <= i_cfg_data[15:0];
                CFG_CLEAR_THR: r_cthr   <= i_cfg_data[15:0];
                CFG_RATE_GAIN: r_rate   <= i_cfg_data[15:0];
                CFG_COEF_A:    r_coef_a <= i_cfg_data;
                CFG_COEF_B:    r_coef_b <= i_cfg_data;
                CFG_COEF_C:    r_coef_c <= i_cfg_data;
                CFG_CEILING:   r_ceil   <= i_cfg_data;
                CFG_FLOOR:     r_floor  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // captured request
    logic signed [15:0] r_mx, r_my;
    logic [31:0]        r_time;
    logic               r_clr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mx   <= i_motion_x;
            r_my   <= i_motion_y;
            r_time <= i_time_ms;
            r_clr  <= i_clear_history;
        end
    end

    // history bookkeeping
    logic [CNT_W-1:0] r_hcount, n_hcount;
    logic [31:0]      r_last;
    logic [PTR_W-1:0] r_wptr, r_rd_ptr;
    logic [31:0]      n_gap32;
    logic             n_clr;
    logic [15:0]      n_gap16;
    logic [47:0]      ram_rdata;

    always_comb begin
        n_gap32 = (r_hcount != '0) ? (r_time - r_last) : 32'd0;
        n_clr   = (n_gap32 >= {16'd0, r_cthr}) || r_clr;
        n_gap16 = n_clr ? r_cthr : n_gap32[15:0];
        if (n_clr)                                  n_hcount = CNT_W'(1);
        else if (r_hcount < CNT_W'(HISTORY_DEPTH)) n_hcount = r_hcount + CNT_W'(1);
        else                                        n_hcount = r_hcount;
    end

    pac_ram #(
        .WIDTH (48),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_wptr),
        .i_wdata ({r_mx, r_my, n_gap16}),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // walk
    logic [SUM_W-1:0] r_sumx, r_sumy;
    logic [DTS_W-1:0] r_dtsum, n_dtsum;
    logic [CNT_W-1:0] r_wcnt, r_left;
    logic [15:0]      e_gap;
    logic [16:0]      e_ax, e_ay;
    logic             e_grp;

    always_comb begin
        e_gap   = ram_rdata[15:0];
        e_ax    = ram_rdata[47] ? (17'd0 - {ram_rdata[47], ram_rdata[47:32]})
                                : {1'b0, ram_rdata[47:32]};
        e_ay    = ram_rdata[31] ? (17'd0 - {ram_rdata[31], ram_rdata[31:16]})
                                : {1'b0, ram_rdata[31:16]};
        e_grp   = (e_gap == 16'd0) || (e_gap >= r_gthr);
        n_dtsum = r_dtsum + (e_grp ? DTS_W'(r_gthr) : DTS_W'(e_gap));
    end

    assign o_sts.walk_stop = e_grp || (n_dtsum >= DTS_W'(r_cthr))
                             || (r_left == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcount <= '0;
            r_last   <= 32'd0;
            r_wptr   <= '0;
        end else if (i_cmd.store) begin
            r_hcount <= n_hcount;
            r_last   <= r_time;
            r_wptr   <= (r_wptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_rd_ptr <= r_wptr;
            r_left   <= n_hcount;
            r_sumx   <= '0;
            r_sumy   <= '0;
            r_dtsum  <= '0;
            r_wcnt   <= '0;
        end else if (i_cmd.walk) begin
            r_rd_ptr <= (r_rd_ptr == '0) ? PTR_W'(HISTORY_DEPTH - 1) : r_rd_ptr - PTR_W'(1);
            r_left   <= r_left - CNT_W'(1);
            r_dtsum  <= n_dtsum;
            r_wcnt   <= r_wcnt + CNT_W'(1);
            if (!e_grp) begin
                r_sumx <= r_sumx + SUM_W'(e_ax);
                r_sumy <= r_sumy + SUM_W'(e_ay);
            end
        end
    end

    // three restoring dividers sharing one step counter: x, y, gap averages
    logic [DIV_W-1:0] r_dq   [3];
    logic [CNT_W-1:0] r_drem [3];
    logic [DIV_W-1:0] n_dq   [3];
    logic [CNT_W-1:0] n_drem [3];
    logic [DC_W-1:0]  r_dcnt;

    always_comb begin
        logic [CNT_W:0] trial;
        for (int k = 0; k < 3; k++) begin
            trial = {r_drem[k], r_dq[k][DIV_W-1]};
            if (trial >= {1'b0, r_wcnt}) begin
                n_drem[k] = CNT_W'(trial - {1'b0, r_wcnt});
                n_dq[k]   = {r_dq[k][DIV_W-2:0], 1'b1};
            end else begin
                n_drem[k] = trial[CNT_W-1:0];
                n_dq[k]   = {r_dq[k][DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= DC_W'(DIV_W);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - DC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq[0] <= DIV_W'({r_sumx, 8'd0});
            r_dq[1] <= DIV_W'({r_sumy, 8'd0});
            r_dq[2] <= DIV_W'({r_dtsum, 8'd0});
            for (int k = 0; k < 3; k++) r_drem[k] <= '0;
        end else if (i_cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                r_dq[k]   <= n_dq[k];
                r_drem[k] <= n_drem[k];
            end
        end
    end

    assign o_sts.div_done = (r_dcnt == '0);

    // multiply chain
    logic [31:0]        r_dt;
    logic [47:0]        r_t2;
    logic signed [47:0] r_pa, r_pb, r_curve, r_gx, r_gy, r_ox, r_oy;
    logic [79:0]        r_acc;
    logic [31:0]        m_x;
    logic [47:0]        m_y;
    logic               m_neg;
    logic [31:0]        m_ypart;
    logic [63:0]        m_prod;
    logic [79:0]        m_shift;
    logic [47:0]        m_sat;
    logic [79:0]        dt_lim;
    logic [31:0]        n_dt;
    logic signed [49:0] s_sum;
    logic [47:0]        s_sat;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [47:0] mag48(input logic [47:0] v);
        return v[47] ? (48'd0 - v) : v;
    endfunction

    function automatic logic signed [47:0] clamp_gain(input logic signed [47:0] g,
                                                      input logic [31:0] ceil_v,
                                                      input logic [31:0] floor_v);
        logic signed [47:0] res;
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        res = g;
        hi  = {{16{ceil_v[31]}}, ceil_v};
        lo  = {{16{floor_v[31]}}, floor_v};
        if (!ceil_v[31] && res > hi)  res = hi;
        if (!floor_v[31] && res < lo) res = lo;
        return res;
    endfunction

    always_comb begin
        m_x   = 32'd0;
        m_y   = 48'd0;
        m_neg = 1'b0;
        case (i_cmd.sel)
            M_DT: begin
                m_x = {16'd0, r_rate};
                m_y = 48'(r_dq[2]);
            end
            M_T2: begin
                m_x = r_dt;
                m_y = {16'd0, r_dt};
            end
            M_A: begin
                m_x   = mag32(r_coef_a);
                m_y   = r_t2;
                m_neg = r_coef_a[31];
            end
            M_B: begin
                m_x   = mag32(r_coef_b);
                m_y   = {16'd0, r_dt};
                m_neg = r_coef_b[31];
            end
            M_CRV: begin
                m_x   = {16'd0, r_rate};
                m_y   = mag48(r_curve);
                m_neg = r_curve[47];
            end
            M_GX: begin
                m_x   = 32'(r_dq[0]);
                m_y   = mag48(r_curve);
                m_neg = r_curve[47];
            end
            M_GY: begin
                m_x   = 32'(r_dq[1]);
                m_y   = mag48(r_curve);
                m_neg = r_curve[47];
            end
            M_OX: begin
                m_x   = mag32({{16{r_mx[15]}}, r_mx});
                m_y   = mag48(r_gx);
                m_neg = r_mx[15] ^ r_gx[47];
            end
            M_OY: begin
                m_x   = mag32({{16{r_my[15]}}, r_my});
                m_y   = mag48(r_gy);
                m_neg = r_my[15] ^ r_gy[47];
            end
            default: ;
        endcase
    end

    assign m_ypart = i_cmd.mul_hi ? {16'd0, m_y[47:32]} : m_y[31:0];
    assign m_prod  = m_x * m_ypart;

    always_comb begin
        case (i_cmd.sel)
            M_T2, M_A, M_B:     m_shift = r_acc >> 16;
            M_CRV, M_GX, M_GY:  m_shift = r_acc >> 8;
            default:            m_shift = r_acc;
        endcase
        m_sat  = sat48(m_neg, m_shift);
        dt_lim = {48'd0, r_gthr, 16'd0};
        if (r_acc > dt_lim)               n_dt = dt_lim[31:0];
        else                              n_dt = r_acc[31:0];
        if (n_dt < ONE_Q16)               n_dt = ONE_Q16;
        s_sum = {{2{r_pa[47]}}, r_pa} - {{2{r_pb[47]}}, r_pb}
                + {{18{r_coef_c[31]}}, r_coef_c};
        if (s_sum[49:47] == 3'b000 || s_sum[49:47] == 3'b111) s_sat = s_sum[47:0];
        else if (s_sum[49])                                  s_sat = SAT_NEG;
        else                                                 s_sat = SAT_POS;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_acc <= {16'd0, m_prod};
        end else if (i_cmd.mul_hi) begin
            r_acc <= r_acc + {m_prod[47:0], 32'd0};
        end
        if (i_cmd.sum) begin
            r_curve <= s_sat;
        end
        if (i_cmd.mul_fin) begin
            case (i_cmd.sel)
                M_DT:    r_dt    <= n_dt;
                M_T2:    r_t2    <= m_sat;
                M_A:     r_pa    <= m_sat;
                M_B:     r_pb    <= m_sat;
                M_CRV:   r_curve <= m_sat;
                M_GX:    r_gx    <= clamp_gain(m_sat, r_ceil, r_floor);
                M_GY:    r_gy    <= clamp_gain(m_sat, r_ceil, r_floor);
                M_OX:    r_ox    <= m_sat;
                M_OY:    r_oy    <= m_sat;
                default: ;
            endcase
        end
    end

    // output register
    logic               r_out_valid;
    logic signed [47:0] r_out_x, r_out_y;

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x <= r_ox;
            r_out_y <= r_oy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scaled_x  = r_out_x;
    assign o_scaled_y  = r_out_y;
endmodule

// File: hdl/pac_ctrl.sv
// Controller FSM: sequences store, history walk, divide and multiply chain.
// Depends on pac_pkg.
module pac_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pac_pkg::t_sts i_sts,
    output pac_pkg::t_cmd o_cmd
);
    import pac_pkg::*;

    t_state   r_state, n_state;
    t_mul_sel r_sel, n_sel;

    function automatic t_mul_sel next_sel(input t_mul_sel s);
        t_mul_sel res;
        case (s)
            M_DT:    res = M_T2;
            M_T2:    res = M_A;
            M_A:     res = M_B;
            M_B:     res = M_CRV;
            M_CRV:   res = M_GX;
            M_GX:    res = M_GY;
            M_GY:    res = M_OX;
            M_OX:    res = M_OY;
            default: res = M_DT;
        endcase
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= M_DT;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_STORE;
            S_STORE:    n_state = S_WALK_RD;
            S_WALK_RD:  n_state = S_WALK_ACC;
            S_WALK_ACC: n_state = i_sts.walk_stop ? S_DIV_INIT : S_WALK_RD;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_MUL_LO;
                    n_sel   = M_DT;
                end
            end
            S_MUL_LO:   n_state = S_MUL_HI;
            S_MUL_HI:   n_state = S_MUL_FIN;
            S_MUL_FIN: begin
                if (r_sel == M_B) begin
                    n_state = S_SUM;
                end else if (r_sel == M_OY) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL_LO;
                    n_sel   = next_sel(r_sel);
                end
            end
            S_SUM: begin
                n_state = S_MUL_LO;
                n_sel   = M_CRV;
            end
            S_OUT:      if (i_sts.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_STORE:    o_cmd.store     = 1'b1;
            S_WALK_ACC: o_cmd.walk      = 1'b1;
            S_DIV_INIT: o_cmd.div_start = 1'b1;
            S_DIV:      o_cmd.div_step  = !i_sts.div_done;
            S_MUL_LO:   o_cmd.mul_lo    = 1'b1;
            S_MUL_HI:   o_cmd.mul_hi    = 1'b1;
            S_MUL_FIN:  o_cmd.mul_fin   = 1'b1;
            S_SUM:      o_cmd.sum       = 1'b1;
            S_OUT:      o_cmd.out_load  = i_sts.out_free;
            default: ;
        endcase
    end
endmodule

// File: hdl/pointer_acceleration_curve.sv
// Top level of the pointer acceleration block: controller plus datapath.
// Depends on pac_pkg, pac_ctrl, pac_datapath (and pac_ram below it).
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  input    | i_in_valid / o_in_ready    | motion_x, motion_y, time, clear
//  output   | o_out_valid / i_out_ready  | scaled_x, scaled_y (Q32.16)
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One request at a time: the next request is taken once the result has been
// loaded into the output register.
// Each request walks 1..HISTORY_DEPTH history entries through the RAM read
// port; DIV_W (28 at depth 16) is the bit count of the shared divider.
// Nine multiplies go through one 32x32 multiplier (low, high, finish steps).
// A new request is taken while the previous result waits at the output.
// Reset is synchronous; the history contents are not cleared, only its count.
module pointer_acceleration_curve #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [15:0]                 i_motion_x,
    input  logic signed [15:0]                 i_motion_y,
    input  logic [31:0]                        i_time_ms,
    input  logic                               i_clear_history,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [47:0]                 o_scaled_x,
    output logic signed [47:0]                 o_scaled_y,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pac_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pac_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    pac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pac_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_motion_x      (i_motion_x),
        .i_motion_y      (i_motion_y),
        .i_time_ms       (i_time_ms),
        .i_clear_history (i_clear_history),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_scaled_x      (o_scaled_x),
        .o_scaled_y      (o_scaled_y)
    );
endmodule

// File: hdl/pac_checker.sv
// Port-level checks for pointer_acceleration_curve, attached by bind.
// No package dependency.
module pac_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic signed [15:0]             i_motion_x,
    input logic signed [15:0]             i_motion_y,
    input logic [31:0]                    i_time_ms,
    input logic                           i_clear_history,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic signed [47:0]             o_scaled_x,
    input logic signed [47:0]             o_scaled_y,
    input logic                           o_cfg_ready
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_scaled_x)
                                        && $stable(o_scaled_y))
        else $error("result changed while stalled");

    // a waiting request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_motion_x)
                                      && $stable(i_motion_y) && $stable(i_time_ms)
                                      && $stable(i_clear_history))
        else $error("request changed while waiting");

    // an accepted request keeps the block busy: no new accept and no new result right after it
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && !$rose(o_out_valid))
        else $error("request not held busy after accept");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // config port never stalls
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port stalled");
endmodule

bind pointer_acceleration_curve pac_checker u_pac_checker (.*);

// File: sim/pointer_acceleration_curve_test.sv
// Self-checking testbench for pointer_acceleration_curve: random-gap request
// stimulus, an in-bench fixed-point predictor of the gain curve and per-field checks.
// Depends on pac_pkg and the RTL under hdl/.
module pointer_acceleration_curve_test;
    import pac_pkg::*;

    localparam int DEPTH = 16;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 28 + 40;
    localparam longint SAT_P = 64'sh7FFF_FFFF_FFFF;
    localparam longint SAT_N = -64'sh8000_0000_0000;

    typedef struct {
        logic signed [47:0] sx;
        logic signed [47:0] sy;
    } t_motion_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic signed [15:0]    i_motion_x = '0;
    logic signed [15:0]    i_motion_y = '0;
    logic [31:0]           i_time_ms = '0;
    logic                  i_clear_history = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [47:0]    o_scaled_x;
    logic signed [47:0]    o_scaled_y;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pointer_acceleration_curve #(.HISTORY_DEPTH(DEPTH)) dut (.*);

    // predictor state
    logic [15:0] grp_thr, clr_thr, rate;
    logic [31:0] ca, cb, cc, ceil_lim, floor_lim;
    logic signed [15:0] hx [DEPTH];
    logic signed [15:0] hy [DEPTH];
    logic [15:0] hgap [DEPTH];
    int unsigned hcount, wr_ptr;
    logic [31:0] prev_time, now_ms;

    t_motion_out pending_motion[$];
    int  errors = 0;
    bit  no_idle = 0;
    bit  hold_req = 0;

    initial forever #1 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    function automatic longint sat_mag(bit neg, logic [63:0] mag);
        if (neg) return (mag > 64'h8000_0000_0000) ? SAT_N : -longint'(mag);
        return (mag > 64'h7FFF_FFFF_FFFF) ? SAT_P : longint'(mag);
    endfunction

    function automatic longint fx_mul(longint a, longint b, int sh);
        logic [63:0]  ua, ub;
        logic [127:0] p;
        logic [63:0]  mag;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = p >> sh;
        mag = (p[127:64] != 0) ? '1 : p[63:0];
        return sat_mag((a < 0) != (b < 0), mag);
    endfunction

    function automatic longint limit_gain(longint crv, longint avg_q8);
        longint g, hi, lo;
        g  = fx_mul(crv, avg_q8, 8);
        hi = longint'($signed(ceil_lim));
        lo = longint'($signed(floor_lim));
        if (hi >= 0 && g > hi) g = hi;
        if (lo >= 0 && g < lo) g = lo;
        return g;
    endfunction

    function automatic t_motion_out accel_motion(logic signed [15:0] mx,
            logic signed [15:0] my, logic [31:0] t, logic clr);
        logic [31:0] gap;
        logic [63:0] sumx, sumy, dtsum, cnt, avgx, avgy, avgt, dt;
        int unsigned k;
        longint t2, crv, gx, gy, s;
        t_motion_out r;
        gap = hcount ? t - prev_time : 32'd0;
        if (gap >= clr_thr || clr) begin
            hcount = 0;
            gap = {16'd0, clr_thr};
        end
        hx[wr_ptr] = mx;
        hy[wr_ptr] = my;
        hgap[wr_ptr] = gap[15:0];
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (hcount < DEPTH) hcount++;
        prev_time = t;
        sumx = 0; sumy = 0; dtsum = 0; cnt = 0;
        for (int i = 0; i < hcount; i++) begin
            k = (wr_ptr + 2 * DEPTH - 1 - i) % DEPTH;
            if (hgap[k] == 0 || hgap[k] >= grp_thr) begin
                dtsum += grp_thr;
                cnt++;
                break;
            end
            sumx += (hx[k] < 0) ? -longint'(hx[k]) : longint'(hx[k]);
            sumy += (hy[k] < 0) ? -longint'(hy[k]) : longint'(hy[k]);
            dtsum += hgap[k];
            cnt++;
            if (dtsum >= clr_thr) break;
        end
        if (cnt == 0) cnt = 1;
        avgx = (sumx << 8) / cnt;
        avgy = (sumy << 8) / cnt;
        avgt = (dtsum << 8) / cnt;
        dt = avgt * rate;
        if (dt > ({48'd0, grp_thr} << 16)) dt = {48'd0, grp_thr} << 16;
        if (dt < ONE_Q16) dt = ONE_Q16;
        t2 = fx_mul(dt, dt, 16);
        s = fx_mul($signed(ca), t2, 16) - fx_mul($signed(cb), dt, 16)
            + longint'($signed(cc));
        crv = (s > SAT_P) ? SAT_P : (s < SAT_N) ? SAT_N : s;
        crv = fx_mul(crv, rate, 8);
        gx = limit_gain(crv, avgx);
        gy = limit_gain(crv, avgy);
        r.sx = fx_mul(mx, gx, 0);
        r.sy = fx_mul(my, gy, 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // send one motion request; valid stays high until the next call or idle_input
    task automatic send_event(logic signed [15:0] mx, logic signed [15:0] my,
            logic [31:0] t, logic clr);
        int n;
        n = no_idle ? 0 : $urandom_range(0, 18);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_motion_x <= mx;
        i_motion_y <= my;
        i_time_ms <= t;
        i_clear_history <= clr;
        do @(posedge i_clk); while (!(o_in_ready && i_in_valid));
        pending_motion.push_back(accel_motion(mx, my, t, clr));
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        idle_input();
        wait (pending_motion.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one write, then config valid is deasserted before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!(o_cfg_ready && i_cfg_valid));
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GROUP_THR: grp_thr = val[15:0];
            CFG_CLEAR_THR: clr_thr = val[15:0];
            CFG_RATE_GAIN: rate = val[15:0];
            CFG_COEF_A:    ca = val;
            CFG_COEF_B:    cb = val;
            CFG_COEF_C:    cc = val;
            CFG_CEILING:   ceil_lim = val;
            CFG_FLOOR:     floor_lim = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_curve(logic [15:0] g, logic [15:0] c, logic [15:0] r,
            logic [31:0] a, logic [31:0] b, logic [31:0] k,
            logic [31:0] hi, logic [31:0] lo);
        drain();
        write_reg(CFG_GROUP_THR, g);
        write_reg(CFG_CLEAR_THR, c);
        write_reg(CFG_RATE_GAIN, r);
        write_reg(CFG_COEF_A, a);
        write_reg(CFG_COEF_B, b);
        write_reg(CFG_COEF_C, k);
        write_reg(CFG_CEILING, hi);
        write_reg(CFG_FLOOR, lo);
    endtask

    task automatic send_random();
        int sel;
        logic signed [15:0] mx, my;
        sel = $urandom_range(0, 99);
        if (sel < 70) now_ms += $urandom_range(1, 40);
        else if (sel < 80) now_ms += 0;
        else if (sel < 92) now_ms += $urandom_range(40, 1200);
        else now_ms = $urandom;
        if ($urandom_range(0, 2) == 0) begin
            mx = 16'($urandom);
            my = 16'($urandom);
        end else begin
            mx = 16'($signed(10'($urandom_range(0, 1023))));
            my = 16'($signed(10'($urandom_range(0, 1023))));
        end
        send_event(mx, my, now_ms, $urandom_range(0, 19) == 0);
    endtask

    // result checker with random and long hold-offs
    initial begin
        t_motion_out want;
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 18);
                if (n > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            if (pending_motion.size() == 0) begin
                report_mismatch("unexpected result x", o_scaled_x, 0);
            end else begin
                want = pending_motion.pop_front();
                if (o_scaled_x !== want.sx) report_mismatch("scaled_x", o_scaled_x, want.sx);
                if (o_scaled_y !== want.sy) report_mismatch("scaled_y", o_scaled_y, want.sy);
            end
        end
    end

    task automatic test_directed();
        now_ms = 32'd5;
        send_event(16'sd10, -16'sd10, now_ms, 1'b0);           // lone event
        send_event(16'sh7FFF, 16'sh8000, now_ms + 3, 1'b0);
        send_event(16'sh8000, 16'sh7FFF, now_ms + 6, 1'b0);
        send_event(-16'sd1, 16'sd0, now_ms + 6, 1'b0);          // zero gap
        send_event(16'sd100, 16'sd50, now_ms + 9, 1'b1);        // clear flag
        send_event(16'sd7, 16'sd9, now_ms + 900, 1'b0);         // long pause
        now_ms = 32'hFFFF_FFF0;
        send_event(16'sd3, -16'sd4, now_ms, 1'b0);
        // wrap the timestamp and overfill the history
        for (int i = 0; i < 18; i++) begin
            now_ms += 32'd2;
            send_event(16'(i * 300), -16'(i * 50), now_ms, 1'b0);
        end
    endtask

    task automatic test_config_extremes();
        load_curve(16'd65535, 16'd65535, 16'd65535, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (60) send_random();
        load_curve(16'd1, 16'd1, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'd0, 32'd0);
        repeat (60) send_random();
        load_curve(16'd40, 16'd300, 16'd512, 32'h0000_0100, 32'h0000_2000,
                   32'h0001_0000, 32'h0004_0000, 32'h0000_8000);
        write_reg(8'd9, $urandom);                              // unmapped index
        repeat (60) send_random();
    endtask

    task automatic test_backpressure();
        drain();
        no_idle = 1;
        hold_req = 1;
        repeat (30) send_random();
        no_idle = 0;
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 8; ph++) begin
            load_curve(16'($urandom_range(2, 200)), 16'($urandom_range(50, 2000)),
                       16'($urandom_range(0, 1024)), 32'($signed(20'($urandom))),
                       32'($signed(24'($urandom))), $urandom_range(0, 32'h0004_0000),
                       ($urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF),
                       ($urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF));
            no_idle = (ph == 3);
            repeat (205) send_random();
            no_idle = 0;
        end
    endtask

    initial begin
        grp_thr = RST_GROUP_THR; clr_thr = RST_CLEAR_THR; rate = RST_RATE_GAIN;
        ca = RST_COEF_A; cb = RST_COEF_B; cc = RST_COEF_C;
        ceil_lim = RST_CEILING; floor_lim = RST_FLOOR;
        hcount = 0; wr_ptr = 0; prev_time = 0; now_ms = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        drain();
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
hdl/pac_pkg.sv
hdl/pac_ram.sv
hdl/pac_datapath.sv
hdl/pac_ctrl.sv
hdl/pointer_acceleration_curve.sv
hdl/pac_checker.sv
sim/pointer_acceleration_curve_test.sv
